>>> hw/rtl/lbd_pkg.sv
// ----------------------------------------------------------------------------
// lbd_pkg
// Shared types and constants of the base64 LZW stream decompressor.
// ----------------------------------------------------------------------------
package lbd_pkg;

   localparam int DICT_ENTRIES_DEF  = 4096;
   localparam int MAX_ENTRY_LEN_DEF = 32;
   localparam int QUEUE_DEPTH       = 4;
   localparam int CHAR_W            = 8;
   localparam int B64_W             = 6;
   localparam int SYM_W             = 16;
   localparam int STATUS_W          = 3;
   localparam int FIRST_ENTRY       = 3;
   localparam int RESET_CODE_WIDTH  = 3;
   localparam int RESET_NEXT_FREE   = 4;
   localparam int FIRST_CODE_BITS   = 2;
   localparam int LIT8_BITS         = 8;
   localparam int LIT16_BITS        = 16;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_SYM   = 3'd0,
      ST_END   = 3'd1,
      ST_BAD   = 3'd2,
      ST_TRUNC = 3'd3,
      ST_FULL  = 3'd4,
      ST_LONG  = 3'd5
   } lbd_status_type;

   // one queued character word: decoded 6 bits and the end marker
   typedef struct packed {
      logic [B64_W-1:0] bits;
      logic             final_char;
   } lbd_word_type;

endpackage

>>> hw/rtl/lbd_if.sv
// ----------------------------------------------------------------------------
// lbd_req_if / lbd_rsp_if
// Valid/ready channels for compressed characters and decoded results.
// ----------------------------------------------------------------------------
interface lbd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       final_char;

   modport source (output valid, char_code, final_char, input ready);
   modport sink   (input valid, char_code, final_char, output ready);
endinterface

interface lbd_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] symbol;
   logic        last_of_run;
   logic [2:0]  status;

   modport source (output valid, symbol, last_of_run, status, input ready);
   modport sink   (input valid, symbol, last_of_run, status, output ready);
endinterface

>>> hw/rtl/lbd_ram.sv
// ----------------------------------------------------------------------------
// lbd_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module lbd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

>>> hw/rtl/lbd_front.sv
// ----------------------------------------------------------------------------
// lbd_front
// Accepts characters, maps them to 6-bit values and queues them.
// ----------------------------------------------------------------------------
module lbd_front import lbd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   lbd_req_if.sink      req_ch,
   output logic         word_valid,
   output lbd_word_type word,
   input  logic         word_pop
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   lbd_word_type     queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   lbd_word_type     push_word;

   // base64 alphabet; '=' is zero, anything unknown is all ones
   function automatic logic [B64_W-1:0] b64_value(input logic [CHAR_W-1:0] ch);
      logic [B64_W-1:0] val;
      val = '1;
      if (ch >= "A" && ch <= "Z") val = B64_W'(ch - "A");
      else if (ch >= "a" && ch <= "z") val = B64_W'(ch - "a" + 8'd26);
      else if (ch >= "0" && ch <= "9") val = B64_W'(ch - "0" + 8'd52);
      else if (ch == "+") val = 6'd62;
      else if (ch == "/") val = 6'd63;
      else if (ch == "=") val = 6'd0;
      return val;
   endfunction

   assign req_ch.ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign push         = req_ch.valid && req_ch.ready;
   assign word_valid   = (count_ff != '0);
   assign word         = queue_ff[rd_ptr_ff];

   assign push_word.bits       = b64_value(req_ch.char_code);
   assign push_word.final_char = req_ch.final_char;

   // pointer and fill count
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = word_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !word_pop) count_in = count_ff + 1'b1;
      else if (!push && word_pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue payload
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

>>> hw/rtl/lbd_back.sv
// ----------------------------------------------------------------------------
// lbd_back
// Bit assembly, LZW code handling, dictionary walk and result output.
// ----------------------------------------------------------------------------
module lbd_back import lbd_pkg::*; #(
   parameter int DICT_ENTRIES  = DICT_ENTRIES_DEF,
   parameter int MAX_ENTRY_LEN = MAX_ENTRY_LEN_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         word_valid,
   input  lbd_word_type word,
   output logic         word_pop,
   lbd_rsp_if.source    rsp_ch
);

   localparam int IDX_W  = $clog2(DICT_ENTRIES);
   localparam int NF_W   = IDX_W + 1;
   localparam int ACC_W  = (IDX_W + 1 > SYM_W) ? IDX_W + 1 : SYM_W;
   localparam int CW_W   = $clog2(ACC_W + 1);
   localparam int ENL_W  = IDX_W + 2;
   localparam int LEN_W  = $clog2(MAX_ENTRY_LEN + 1);
   localparam int SIDX_W = $clog2(MAX_ENTRY_LEN);
   localparam int ENT_W  = IDX_W + 2 * SYM_W + LEN_W;

   typedef enum logic [6:0] {
      PH_FIRST     = 7'b0000001,
      PH_FIRST_L8  = 7'b0000010,
      PH_FIRST_L16 = 7'b0000100,
      PH_CODE      = 7'b0001000,
      PH_L8        = 7'b0010000,
      PH_L16       = 7'b0100000,
      PH_HALT      = 7'b1000000
   } lbd_phase_type;

   typedef enum logic [12:0] {
      S_IDLE  = 13'b0000000000001,
      S_BIT   = 13'b0000000000010,
      S_NEXT  = 13'b0000000000100,
      S_TAIL  = 13'b0000000001000,
      S_STOP  = 13'b0000000010000,
      S_FLUSH = 13'b0000000100000,
      S_LIT   = 13'b0000001000000,
      S_R0    = 13'b0000010000000,
      S_R1    = 13'b0000100000000,
      S_R2    = 13'b0001000000000,
      S_W0    = 13'b0010000000000,
      S_W1    = 13'b0100000000000,
      S_EMIT  = 13'b1000000000000
   } lbd_state_type;

   lbd_state_type  state_ff, state_in;
   lbd_phase_type  phase_ff, phase_in;
   logic [B64_W-1:0] bits_ff, bits_in;
   logic           fin_ff, fin_in;
   logic [2:0]     bidx_ff, bidx_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [CW_W-1:0]  gath_ff, gath_in;
   logic [CW_W-1:0]  cw_ff, cw_in;
   logic [ENL_W-1:0] enl_ff, enl_in;
   logic [NF_W-1:0]  nf_ff, nf_in;
   logic [IDX_W-1:0] prev_ff, prev_in;
   logic [ACC_W-1:0] code_ff, code_in;
   logic [SYM_W-1:0] lit_ff, lit_in;
   lbd_status_type   stat_ff, stat_in;
   logic [SYM_W-1:0] wfirst_ff, wfirst_in;
   logic [LEN_W-1:0] wlen_ff, wlen_in;
   logic [LEN_W-1:0] n_ff, n_in;
   logic [LEN_W-1:0] k_ff, k_in;
   logic [LEN_W-1:0] e_ff, e_in;

   // result hold stage and output register
   logic             hold_vld_ff, hold_vld_in;
   logic [SYM_W-1:0] hold_sym_ff, hold_sym_in;
   lbd_status_type   hold_stat_ff, hold_stat_in;
   logic             rsp_vld_ff, rsp_vld_in;
   logic [SYM_W-1:0] rsp_sym_ff, rsp_sym_in;
   logic             rsp_last_ff, rsp_last_in;
   lbd_status_type   rsp_stat_ff, rsp_stat_in;

   logic [SYM_W-1:0] stack_ff [MAX_ENTRY_LEN];
   logic             stack_we;
   logic [SIDX_W-1:0] stack_waddr;
   logic [SYM_W-1:0] stack_wdata;

   logic             ram_we;
   logic [IDX_W-1:0] ram_waddr, ram_raddr;
   logic [ENT_W-1:0] ram_wdata, ram_rdata;
   logic [IDX_W-1:0] rd_prefix;
   logic [SYM_W-1:0] rd_first, rd_last;
   logic [LEN_W-1:0] rd_len;

   logic             em_valid, em_go, out_free, flush_push;
   logic [SYM_W-1:0] em_sym;
   lbd_status_type   em_stat;

   logic             cur_bit;
   logic [ACC_W-1:0] acc_new;
   logic [CW_W-1:0]  gath_new, need;
   logic [LEN_W:0]   nl;
   logic             self_ref;
   logic [LEN_W-1:0] km1;

   lbd_ram #(.WIDTH(ENT_W), .DEPTH(DICT_ENTRIES)) u_dict (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // entry layout: prefix, first symbol, last symbol, length
   assign rd_prefix = ram_rdata[ENT_W-1 -: IDX_W];
   assign rd_first  = ram_rdata[LEN_W+SYM_W +: SYM_W];
   assign rd_last   = ram_rdata[LEN_W +: SYM_W];
   assign rd_len    = ram_rdata[LEN_W-1:0];

   // bit assembly
   assign cur_bit  = bits_ff[bidx_ff];
   assign acc_new  = acc_ff | (ACC_W'(cur_bit) << gath_ff);
   assign gath_new = gath_ff + 1'b1;
   assign nl       = {1'b0, wlen_ff} + 1'b1;
   assign self_ref = (code_ff == ACC_W'(nf_ff));
   assign km1      = k_ff - 1'b1;

   always_comb begin
      case (phase_ff)
         PH_FIRST:                need = CW_W'(FIRST_CODE_BITS);
         PH_FIRST_L8, PH_L8:      need = CW_W'(LIT8_BITS);
         PH_FIRST_L16, PH_L16:    need = CW_W'(LIT16_BITS);
         default:                 need = cw_ff;
      endcase
   end

   // output handshake
   assign out_free   = !rsp_vld_ff || rsp_ch.ready;
   assign em_go      = em_valid && (!hold_vld_ff || out_free);
   assign flush_push = (state_ff == S_FLUSH) && hold_vld_ff && out_free;

   assign rsp_ch.valid       = rsp_vld_ff;
   assign rsp_ch.symbol      = rsp_sym_ff;
   assign rsp_ch.last_of_run = rsp_last_ff;
   assign rsp_ch.status      = rsp_stat_ff;

   // sequencer
   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      bits_in   = bits_ff;
      fin_in    = fin_ff;
      bidx_in   = bidx_ff;
      acc_in    = acc_ff;
      gath_in   = gath_ff;
      cw_in     = cw_ff;
      enl_in    = enl_ff;
      nf_in     = nf_ff;
      prev_in   = prev_ff;
      code_in   = code_ff;
      lit_in    = lit_ff;
      stat_in   = stat_ff;
      wfirst_in = wfirst_ff;
      wlen_in   = wlen_ff;
      n_in      = n_ff;
      k_in      = k_ff;
      e_in      = e_ff;
      word_pop  = 1'b0;
      ram_we    = 1'b0;
      ram_waddr = '0;
      ram_wdata = '0;
      ram_raddr = '0;
      stack_we    = 1'b0;
      stack_waddr = km1[SIDX_W-1:0];
      stack_wdata = rd_last;
      em_valid  = 1'b0;
      em_sym    = '0;
      em_stat   = ST_SYM;

      case (state_ff)
         S_IDLE: begin
            if (word_valid) begin
               word_pop = 1'b1;
               if (phase_ff != PH_HALT) begin
                  bits_in  = word.bits;
                  fin_in   = word.final_char;
                  bidx_in  = 3'd5;
                  state_in = S_BIT;
               end
            end
         end

         S_BIT: begin
            if (gath_new >= need) begin
               acc_in   = '0;
               gath_in  = '0;
               state_in = S_NEXT;
               case (phase_ff)
                  PH_FIRST, PH_CODE: begin
                     if (acc_new == ACC_W'(0)) begin
                        phase_in = (phase_ff == PH_FIRST) ? PH_FIRST_L8 : PH_L8;
                     end else if (acc_new == ACC_W'(1)) begin
                        phase_in = (phase_ff == PH_FIRST) ? PH_FIRST_L16 : PH_L16;
                     end else if (acc_new == ACC_W'(2)) begin
                        stat_in  = ST_END;
                        state_in = S_STOP;
                     end else if (phase_ff == PH_FIRST) begin
                        stat_in  = ST_BAD;
                        state_in = S_STOP;
                     end else begin
                        code_in  = acc_new;
                        state_in = S_R0;
                     end
                  end
                  PH_FIRST_L8, PH_FIRST_L16: begin
                     ram_we    = 1'b1;
                     ram_waddr = IDX_W'(FIRST_ENTRY);
                     ram_wdata = {IDX_W'(0), acc_new[SYM_W-1:0], acc_new[SYM_W-1:0],
                                  LEN_W'(1)};
                     prev_in   = IDX_W'(FIRST_ENTRY);
                     lit_in    = acc_new[SYM_W-1:0];
                     phase_in  = PH_CODE;
                     state_in  = S_LIT;
                  end
                  PH_L8, PH_L16: begin
                     if (nf_ff >= NF_W'(DICT_ENTRIES)) begin
                        stat_in  = ST_FULL;
                        state_in = S_STOP;
                     end else begin
                        ram_we    = 1'b1;
                        ram_waddr = nf_ff[IDX_W-1:0];
                        ram_wdata = {IDX_W'(0), acc_new[SYM_W-1:0], acc_new[SYM_W-1:0],
                                     LEN_W'(1)};
                        nf_in     = nf_ff + 1'b1;
                        enl_in    = enl_ff - 1'b1;
                        code_in   = ACC_W'(nf_ff);
                        phase_in  = PH_CODE;
                        state_in  = S_R0;
                     end
                  end
                  default: state_in = S_NEXT;
               endcase
            end else begin
               acc_in   = acc_new;
               gath_in  = gath_new;
               state_in = S_NEXT;
            end
         end

         S_NEXT: begin
            if (bidx_ff == 3'd0) begin
               state_in = S_TAIL;
            end else begin
               bidx_in  = bidx_ff - 1'b1;
               state_in = S_BIT;
            end
         end

         S_TAIL: begin
            if (fin_ff) begin
               stat_in  = ST_TRUNC;
               state_in = S_STOP;
            end else begin
               state_in = S_FLUSH;
            end
         end

         S_STOP: begin
            em_valid = 1'b1;
            em_stat  = stat_ff;
            if (em_go) begin
               phase_in = PH_HALT;
               state_in = S_FLUSH;
            end
         end

         S_FLUSH: begin
            if (!hold_vld_ff || out_free) state_in = S_IDLE;
         end

         S_LIT: begin
            em_valid = 1'b1;
            em_sym   = lit_ff;
            if (em_go) state_in = S_NEXT;
         end

         // grow the code width, range checks, fetch the previous entry
         S_R0: begin
            if (enl_ff == '0) begin
               enl_in = ENL_W'(1) << cw_ff;
               cw_in  = cw_ff + 1'b1;
            end
            if (code_ff > ACC_W'(nf_ff)) begin
               stat_in  = ST_BAD;
               state_in = S_STOP;
            end else if (nf_ff >= NF_W'(DICT_ENTRIES)) begin
               stat_in  = ST_FULL;
               state_in = S_STOP;
            end else begin
               ram_raddr = prev_ff;
               state_in  = S_R1;
            end
         end

         S_R1: begin
            wfirst_in = rd_first;
            wlen_in   = rd_len;
            ram_raddr = code_ff[IDX_W-1:0];
            state_in  = S_R2;
         end

         // add prev + first(code) to the dictionary
         S_R2: begin
            if (nl > (LEN_W+1)'(MAX_ENTRY_LEN)) begin
               stat_in  = ST_LONG;
               state_in = S_STOP;
            end else begin
               ram_we    = 1'b1;
               ram_waddr = nf_ff[IDX_W-1:0];
               ram_wdata = {prev_ff, wfirst_ff, self_ref ? wfirst_ff : rd_first,
                            nl[LEN_W-1:0]};
               n_in      = self_ref ? nl[LEN_W-1:0] : rd_len;
               nf_in     = nf_ff + 1'b1;
               enl_in    = enl_ff - 1'b1;
               state_in  = S_W0;
            end
         end

         S_W0: begin
            ram_raddr = code_ff[IDX_W-1:0];
            k_in      = n_ff;
            state_in  = S_W1;
         end

         // walk the prefix chain, filling the stack from the back
         S_W1: begin
            stack_we  = 1'b1;
            k_in      = km1;
            ram_raddr = rd_prefix;
            if (k_ff == LEN_W'(1)) begin
               e_in     = '0;
               state_in = S_EMIT;
            end
         end

         S_EMIT: begin
            em_valid = 1'b1;
            em_sym   = stack_ff[e_ff[SIDX_W-1:0]];
            if (em_go) begin
               e_in = e_ff + 1'b1;
               if (e_ff + 1'b1 == n_ff) begin
                  prev_in = code_ff[IDX_W-1:0];
                  if (enl_ff == '0) begin
                     enl_in = ENL_W'(1) << cw_ff;
                     cw_in  = cw_ff + 1'b1;
                  end
                  state_in = S_NEXT;
               end
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // hold stage keeps the newest result until the next one or the end of the word
   always_comb begin
      hold_vld_in  = hold_vld_ff;
      hold_sym_in  = hold_sym_ff;
      hold_stat_in = hold_stat_ff;
      rsp_vld_in   = rsp_vld_ff;
      rsp_sym_in   = rsp_sym_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_stat_in  = rsp_stat_ff;
      if (rsp_ch.ready) rsp_vld_in = 1'b0;
      if ((em_go && hold_vld_ff) || flush_push) begin
         rsp_vld_in  = 1'b1;
         rsp_sym_in  = hold_sym_ff;
         rsp_stat_in = hold_stat_ff;
         rsp_last_in = flush_push;
      end
      if (em_go) begin
         hold_vld_in  = 1'b1;
         hold_sym_in  = em_sym;
         hold_stat_in = em_stat;
      end else if (flush_push) begin
         hold_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         phase_ff    <= PH_FIRST;
         acc_ff      <= '0;
         gath_ff     <= '0;
         cw_ff       <= CW_W'(RESET_CODE_WIDTH);
         enl_ff      <= ENL_W'(RESET_NEXT_FREE);
         nf_ff       <= NF_W'(RESET_NEXT_FREE);
         prev_ff     <= '0;
         hold_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         phase_ff    <= phase_in;
         acc_ff      <= acc_in;
         gath_ff     <= gath_in;
         cw_ff       <= cw_in;
         enl_ff      <= enl_in;
         nf_ff       <= nf_in;
         prev_ff     <= prev_in;
         hold_vld_ff <= hold_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      bits_ff      <= bits_in;
      fin_ff       <= fin_in;
      bidx_ff      <= bidx_in;
      code_ff      <= code_in;
      lit_ff       <= lit_in;
      stat_ff      <= stat_in;
      wfirst_ff    <= wfirst_in;
      wlen_ff      <= wlen_in;
      n_ff         <= n_in;
      k_ff         <= k_in;
      e_ff         <= e_in;
      hold_sym_ff  <= hold_sym_in;
      hold_stat_ff <= hold_stat_in;
      rsp_sym_ff   <= rsp_sym_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_stat_ff  <= rsp_stat_in;
      if (stack_we) begin
         stack_ff[stack_waddr] <= stack_wdata;
      end
   end

endmodule

>>> hw/rtl/lzw_base64_stream_decompressor.sv
// ----------------------------------------------------------------------------
// lzw_base64_stream_decompressor
// Decodes base64 LZW text one character per word into 16-bit symbols.
// ----------------------------------------------------------------------------
// Characters enter a four-word queue and are decoded one at a time by the
// back end, bit by bit. A dictionary reference reads the entry RAM, which
// has a single registered read port; the prefix chain is walked one entry
// per cycle, and the symbols then go out one per cycle while the receiver
// does not stall. Results leave through a hold stage and an output register;
// the last result of each character carries last_of_run, and a stalled
// receiver holds the back end. After an end code or an error the block
// drops every further character until reset. No clearing pass follows
// reset.
module lzw_base64_stream_decompressor import lbd_pkg::*; #(
   parameter int DICT_ENTRIES  = DICT_ENTRIES_DEF,
   parameter int MAX_ENTRY_LEN = MAX_ENTRY_LEN_DEF
) (
   input  logic      clock,
   input  logic      reset,
   lbd_req_if.sink   req_ch,
   lbd_rsp_if.source rsp_ch
);

   logic         word_valid;
   logic         word_pop;
   lbd_word_type word;

   lbd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .word_valid (word_valid),
      .word       (word),
      .word_pop   (word_pop)
   );

   lbd_back #(
      .DICT_ENTRIES  (DICT_ENTRIES),
      .MAX_ENTRY_LEN (MAX_ENTRY_LEN)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .word_valid (word_valid),
      .word       (word),
      .word_pop   (word_pop),
      .rsp_ch     (rsp_ch)
   );

   // end and error results always close their character's run
   a_stop_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.status != ST_SYM) |-> rsp_ch.last_of_run)
      else $error("stop result without last_of_run");

   // only symbol results carry a symbol
   a_stop_zero_sym: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.status != ST_SYM) |-> (rsp_ch.symbol == '0))
      else $error("stop result with nonzero symbol");

   // no result directly after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("result valid right after reset");

endmodule
